// ===== sv/dtpf_pkg.sv =====
`timescale 1ns / 1ps

package dtpf_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int MAX_DIGITS = 10;
    localparam int RADIX      = 10;

    localparam int DIGIT_W  = 4;
    localparam int CNT_W    = 4;
    localparam int DIGITS_W = MAX_DIGITS * DIGIT_W;
    localparam int LINK_W   = $clog2(NODE_COUNT);
    localparam int USED_W   = $clog2(NODE_COUNT + 1);
    localparam int DEPTH_W  = $clog2(MAX_DIGITS + 1);
    // One memory row per node: RADIX child links, end mark in the top bit.
    localparam int ROW_W    = RADIX * LINK_W + 1;
    localparam int END_BIT  = ROW_W - 1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_CONFLICT  = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_POOL_FULL = 3'd3,
        ST_BAD_DIGIT = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHK,
        S_ALLOC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    consistent;
        t_status status;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [LINK_W-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic [LINK_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [DIGIT_W-1:0] digit_at(input logic [DIGITS_W-1:0] digits,
                                                    input logic [DEPTH_W-1:0]  pos);
        logic [DIGIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (pos == DEPTH_W'(i)) begin
                r = digits[i*DIGIT_W +: DIGIT_W];
            end
        end
        return r;
    endfunction

    function automatic logic [LINK_W-1:0] link_at(input logic [ROW_W-1:0]   row,
                                                  input logic [DIGIT_W-1:0] d);
        logic [LINK_W-1:0] r;
        r = '0;
        for (int i = 0; i < RADIX; i++) begin
            if (d == DIGIT_W'(i)) begin
                r = row[i*LINK_W +: LINK_W];
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] set_link(input logic [ROW_W-1:0]   row,
                                                  input logic [DIGIT_W-1:0] d,
                                                  input logic [LINK_W-1:0]  val);
        logic [ROW_W-1:0] r;
        r = row;
        for (int i = 0; i < RADIX; i++) begin
            if (d == DIGIT_W'(i)) begin
                r[i*LINK_W +: LINK_W] = val;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/dtpf_ram.sv =====
`timescale 1ns / 1ps

module dtpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dtpf_ctrl.sv =====
`timescale 1ns / 1ps

module dtpf_ctrl import dtpf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_new_set,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [DIGITS_W-1:0] i_digits,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res,
    output t_mem_req            o_mem,
    input  logic [ROW_W-1:0]    i_rdata
);

    t_state              r_state, n_state;
    logic [USED_W-1:0]   r_nodes_used, n_nodes_used;
    logic                r_conflict, n_conflict;
    logic                r_blank, n_blank;
    logic [DIGITS_W-1:0] r_digits, n_digits;
    logic [DEPTH_W-1:0]  r_count, n_count;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [LINK_W-1:0]   r_node, n_node;
    t_result             r_res, n_res;

    logic [DEPTH_W-1:0]  cnt_sat;
    logic                bad_digit;
    logic                conflict_eff;
    logic [ROW_W-1:0]    row;
    logic [DIGIT_W-1:0]  cur_digit;
    logic [LINK_W-1:0]   next_link;
    logic [USED_W:0]     pool_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_nodes_used <= USED_W'(1);
            r_conflict   <= 1'b0;
            r_blank      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_conflict   <= n_conflict;
            r_blank      <= n_blank;
        end
        r_digits <= n_digits;
        r_count  <= n_count;
        r_depth  <= n_depth;
        r_node   <= n_node;
        r_res    <= n_res;
    end

    always_comb begin
        if (int'(i_count) > MAX_DIGITS) begin
            cnt_sat = DEPTH_W'(MAX_DIGITS);
        end else begin
            cnt_sat = DEPTH_W'(i_count);
        end
        bad_digit = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if ((DEPTH_W'(i) < cnt_sat) &&
                (int'(i_digits[i*DIGIT_W +: DIGIT_W]) >= RADIX)) begin
                bad_digit = 1'b1;
            end
        end
        conflict_eff = r_conflict && !i_new_set;
        // Right after a new set starts, the root row is known to be empty.
        row       = r_blank ? '0 : i_rdata;
        cur_digit = digit_at(r_digits, r_depth);
        next_link = link_at(row, cur_digit);
        pool_sum  = {1'b0, r_nodes_used} + (USED_W+1)'(r_count - r_depth);
    end

    always_comb begin
        n_state      = r_state;
        n_nodes_used = r_nodes_used;
        n_conflict   = r_conflict;
        n_blank      = r_blank;
        n_digits     = r_digits;
        n_count      = r_count;
        n_depth      = r_depth;
        n_node       = r_node;
        n_res        = r_res;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_node;
        o_mem.wdata  = '0;
        o_mem.raddr  = '0;

        case (r_state)
            S_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = '0;
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_digits = i_digits;
                    n_count  = cnt_sat;
                    n_depth  = '0;
                    n_node   = '0;
                    n_blank  = i_new_set;
                    if (i_new_set) begin
                        n_nodes_used = USED_W'(1);
                        n_conflict   = 1'b0;
                        o_mem.we     = 1'b1;
                        o_mem.waddr  = '0;
                    end
                    if (conflict_eff) begin
                        n_res   = '{consistent: 1'b0, status: ST_IGNORED};
                        n_state = S_OUT;
                    end else if (i_count == '0) begin
                        n_conflict = 1'b1;
                        n_res      = '{consistent: 1'b0, status: ST_CONFLICT};
                        n_state    = S_OUT;
                    end else if (bad_digit) begin
                        n_res   = '{consistent: 1'b1, status: ST_BAD_DIGIT};
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_blank = 1'b0;
                if (((r_depth != '0) && row[END_BIT]) || (r_depth == r_count)) begin
                    n_conflict = 1'b1;
                    n_res      = '{consistent: 1'b0, status: ST_CONFLICT};
                    n_state    = S_OUT;
                end else if (next_link != '0) begin
                    o_mem.raddr = next_link;
                    n_node      = next_link;
                    n_depth     = r_depth + 1'b1;
                end else if (pool_sum > (USED_W+1)'(NODE_COUNT)) begin
                    n_res   = '{consistent: 1'b1, status: ST_POOL_FULL};
                    n_state = S_OUT;
                end else begin
                    // Branch point: hook the first fresh node into this row.
                    o_mem.we     = 1'b1;
                    o_mem.wdata  = set_link(row, cur_digit, r_nodes_used[LINK_W-1:0]);
                    n_node       = r_nodes_used[LINK_W-1:0];
                    n_nodes_used = r_nodes_used + 1'b1;
                    n_depth      = r_depth + 1'b1;
                    n_state      = S_ALLOC;
                end
            end
            S_ALLOC: begin
                // Fresh nodes are written whole, so stale rows never leak in.
                o_mem.we = 1'b1;
                if (r_depth == r_count) begin
                    o_mem.wdata          = '0;
                    o_mem.wdata[END_BIT] = 1'b1;
                    n_res                = '{consistent: 1'b1, status: ST_INSERTED};
                    n_state              = S_OUT;
                end else begin
                    o_mem.wdata  = set_link('0, cur_digit, r_nodes_used[LINK_W-1:0]);
                    n_node       = r_nodes_used[LINK_W-1:0];
                    n_nodes_used = r_nodes_used + 1'b1;
                    n_depth      = r_depth + 1'b1;
                end
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== sv/digit_trie_prefix_free_check_top.sv =====
`timescale 1ns / 1ps

// Prefix-free check of a set of decimal numbers held in a digit trie.
//
// Input channel (s_axis): one beat carries one number of up to ten digits,
// first digit in the lowest nibble. tuser marks the first number of a new
// set; that beat clears the trie and the sticky conflict before it is used.
// Output channel (m_axis): exactly one beat per input beat, in order, with
// the set-consistent flag and a status code.
//
// The trie lives in one node memory, one row per node holding every child
// link and the end mark. The walk reads one row per cycle; each new node
// is then written once, whole. A conflict or an error ends the walk
// early. The block takes one number at a time; tready rises again on the
// cycle after the result has moved to the output register.
//
// Reset writes an empty root row in the S_INIT state, then tready rises.
// A stalled receiver holds the result in the output register; one further
// number may be worked on, and it waits for the register to drain.

module digit_trie_prefix_free_check_top import dtpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [3:0] digit_count, [43:4] digits, rest zero
    input  logic        s_axis_tuser,  // [0] new_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [0] set_consistent, [3:1] status, rest zero
);

    t_mem_req         mem_req;
    logic [ROW_W-1:0] mem_rdata;
    t_result          res;
    logic             res_valid;
    logic             res_ready;

    logic             r_out_valid, n_out_valid;
    t_result          r_out;

    dtpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_new_set   (s_axis_tuser),
        .i_count     (s_axis_tdata[CNT_W-1:0]),
        .i_digits    (s_axis_tdata[CNT_W +: DIGITS_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    // Node table: one row per node, written whole at allocation.
    dtpf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: free when empty or when its beat leaves this cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.status, r_out.consistent};

endmodule
